// ----- hw/rtl/ctfv_pkg.sv -----
// Package for the canonical text field validator.
// Holds the format codes, size constants, the running field state type and
// the character class helpers. No dependencies.
package ctfv_pkg;

    localparam int MAX_FIELD_BYTES = 256;
    localparam int POS_W           = $clog2(MAX_FIELD_BYTES + 1);

    localparam logic [POS_W-1:0] C_MAX_POS = POS_W'(MAX_FIELD_BYTES);

    // format codes
    localparam logic [2:0] FMT_DNS63   = 3'd0;
    localparam logic [2:0] FMT_DNS253  = 3'd1;
    localparam logic [2:0] FMT_UUID    = 3'd2;
    localparam logic [2:0] FMT_HEX64   = 3'd3;
    localparam logic [2:0] FMT_IPV4    = 3'd4;
    localparam logic [2:0] FMT_SERVICE = 3'd5;

    // length limits and positions
    localparam logic [7:0] C_DNS63_MAX  = 8'd63;
    localparam logic [7:0] C_DNS253_MAX = 8'd253;
    localparam logic [7:0] C_UUID_LEN   = 8'd36;
    localparam logic [7:0] C_HEX64_LEN  = 8'd64;
    localparam logic [7:0] C_IPV4_MAX   = 8'd15;
    localparam logic [7:0] C_UUID_H0    = 8'd8;
    localparam logic [7:0] C_UUID_H1    = 8'd13;
    localparam logic [7:0] C_UUID_H2    = 8'd18;
    localparam logic [7:0] C_UUID_H3    = 8'd23;
    localparam logic [9:0] C_OCTET_MAX  = 10'd255;
    localparam logic [2:0] C_OCTETS_M1  = 3'd3;
    localparam logic [2:0] C_OCT_SAT    = 3'd7;
    localparam logic [1:0] C_DIG_MAX    = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef struct packed {
        logic [POS_W-1:0] byte_pos;
        logic [2:0]       fmt;
        logic             nul_seen;
        logic [7:0]       text_len;
        logic             failed;
        logic             at_label_start;
        logic             prev_hyphen;
        logic             prev_dot;
        logic [2:0]       octet_cnt;
        logic [1:0]       digit_cnt;
        logic [9:0]       octet_val;
        logic             leading_zero;
    } t_fld_state;

    localparam t_fld_state C_FLD_CLEAR = '{
        byte_pos:       '0,
        fmt:            FMT_DNS63,
        nul_seen:       1'b0,
        text_len:       8'd0,
        failed:         1'b0,
        at_label_start: 1'b1,
        prev_hyphen:    1'b0,
        prev_dot:       1'b0,
        octet_cnt:      3'd0,
        digit_cnt:      2'd0,
        octet_val:      10'd0,
        leading_zero:   1'b0
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic is_label_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || is_digit(c) || (c == CH_HYPHEN);
    endfunction

endpackage

// ----- hw/rtl/ctfv_char_check.sv -----
// Next-state logic for one field byte of the canonical text field validator.
// Applies the per-format character and end-of-text rules. Uses ctfv_pkg.
module ctfv_char_check
    import ctfv_pkg::*;
(
    input  t_fld_state i_st,
    input  logic [2:0] i_fmt,
    input  logic [7:0] i_byte,
    output t_fld_state o_st
);

    always_comb begin
        t_fld_state s;
        logic [9:0] oct_next;
        logic [7:0] lim;
        logic [9:0] digit;

        s        = i_st;
        digit    = {2'b00, i_byte - CH_ZERO};
        oct_next = (i_st.octet_val << 3) + (i_st.octet_val << 1) + digit;
        lim      = (i_st.fmt == FMT_DNS253) ? C_DNS253_MAX : C_DNS63_MAX;

        // format is taken from the first byte only
        if (i_st.byte_pos == '0) begin
            s.fmt = i_fmt;
        end
        if (s.fmt == FMT_DNS253) begin
            lim = C_DNS253_MAX;
        end else begin
            lim = C_DNS63_MAX;
        end

        if (i_st.byte_pos >= C_MAX_POS) begin
            s.failed = 1'b1;
        end else if (!i_st.nul_seen) begin
            if (i_byte == CH_NUL) begin
                s.nul_seen = 1'b1;
                case (s.fmt)
                    FMT_DNS63, FMT_DNS253, FMT_SERVICE: begin
                        if (i_st.text_len == 8'd0) begin
                            if (s.fmt != FMT_SERVICE) s.failed = 1'b1;
                        end else if (i_st.text_len > lim || i_st.prev_hyphen
                                     || i_st.prev_dot) begin
                            s.failed = 1'b1;
                        end
                    end
                    FMT_UUID: begin
                        if (i_st.text_len != C_UUID_LEN) s.failed = 1'b1;
                    end
                    FMT_HEX64: begin
                        if (i_st.text_len != C_HEX64_LEN) s.failed = 1'b1;
                    end
                    FMT_IPV4: begin
                        if (i_st.text_len == 8'd0 || i_st.text_len > C_IPV4_MAX
                            || i_st.digit_cnt == 2'd0 || i_st.octet_cnt != C_OCTETS_M1) begin
                            s.failed = 1'b1;
                        end
                    end
                    default: begin
                        s.failed = 1'b1;
                    end
                endcase
            end else begin
                case (s.fmt)
                    FMT_DNS63, FMT_DNS253, FMT_SERVICE: begin
                        if (i_byte == CH_DOT) begin
                            if (i_st.at_label_start || i_st.prev_hyphen) s.failed = 1'b1;
                            s.at_label_start = 1'b1;
                            s.prev_dot       = 1'b1;
                            s.prev_hyphen    = 1'b0;
                        end else if (is_label_char(i_byte)) begin
                            if (i_st.at_label_start && i_byte == CH_HYPHEN) s.failed = 1'b1;
                            s.at_label_start = 1'b0;
                            s.prev_dot       = 1'b0;
                            s.prev_hyphen    = (i_byte == CH_HYPHEN);
                        end else begin
                            s.failed = 1'b1;
                        end
                    end
                    FMT_UUID: begin
                        if (i_st.text_len == C_UUID_H0 || i_st.text_len == C_UUID_H1
                            || i_st.text_len == C_UUID_H2 || i_st.text_len == C_UUID_H3) begin
                            if (i_byte != CH_HYPHEN) s.failed = 1'b1;
                        end else if (!is_lower_hex(i_byte)) begin
                            s.failed = 1'b1;
                        end
                    end
                    FMT_HEX64: begin
                        if (!is_lower_hex(i_byte)) s.failed = 1'b1;
                    end
                    FMT_IPV4: begin
                        if (is_digit(i_byte)) begin
                            if (i_st.digit_cnt == 2'd0) begin
                                s.leading_zero = (digit == 10'd0);
                                s.octet_val    = digit;
                                s.digit_cnt    = 2'd1;
                            end else if (i_st.leading_zero || i_st.digit_cnt >= C_DIG_MAX) begin
                                s.failed = 1'b1;
                            end else begin
                                // at most two digits held, so the product stays below 1000
                                if (oct_next > C_OCTET_MAX) begin
                                    s.failed    = 1'b1;
                                    s.octet_val = C_OCTET_MAX;
                                end else begin
                                    s.octet_val = oct_next;
                                end
                                s.digit_cnt = i_st.digit_cnt + 2'd1;
                            end
                        end else if (i_byte == CH_DOT) begin
                            if (i_st.digit_cnt == 2'd0 || i_st.octet_cnt >= C_OCTETS_M1) begin
                                s.failed = 1'b1;
                            end
                            if (i_st.octet_cnt < C_OCT_SAT) s.octet_cnt = i_st.octet_cnt + 3'd1;
                            s.digit_cnt    = 2'd0;
                            s.octet_val    = 10'd0;
                            s.leading_zero = 1'b0;
                        end else begin
                            s.failed = 1'b1;
                        end
                    end
                    default: begin
                        s.failed = 1'b1;
                    end
                endcase
                s.text_len = i_st.text_len + 8'd1;
            end
        end else if (i_byte != CH_NUL) begin
            s.failed = 1'b1;
        end

        // saturate the position at the capacity
        if (i_st.byte_pos < C_MAX_POS) begin
            s.byte_pos = i_st.byte_pos + POS_W'(1);
        end

        o_st = s;
    end

endmodule

// ----- hw/rtl/canonical_text_field_validator_top.sv -----
// Top level of the canonical text field validator: stream ports, input
// register, running field state and result register. Uses ctfv_pkg and ctfv_char_check.

// One field byte is accepted per cycle unless the input side stalls. Each
// byte is held in the input register, then the per-byte rule logic updates
// the field state; the byte marked last also loads the result register,
// whose verdict drives the output. The input side stalls only while a finished
// result is waiting in the result register and the byte in the input register
// is another last byte. tuser carries the format code, read on the first byte
// of each field; tlast marks the final byte of the field.
module canonical_text_field_validator_top
    import ctfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic [2:0]  i_s_tuser,   // [2:0] format
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [0] valid_res, [8:1] text_length, [15:9] zero
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [2:0] r_in_fmt;
    logic       r_in_last;

    t_fld_state r_st;
    t_fld_state n_st;

    logic       r_out_valid;
    logic       r_out_ok;
    logic [7:0] r_out_len;

    logic advance;
    logic in_acc;

    // a non-last byte never needs the result slot
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_acc     = i_s_tvalid && o_s_tready;

    ctfv_char_check u_check (
        .i_st   (r_st),
        .i_fmt  (r_in_fmt),
        .i_byte (r_in_byte),
        .o_st   (n_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_s_tdata;
            r_in_fmt  <= i_s_tuser;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_FLD_CLEAR;
        end else if (advance) begin
            // clear the field state after its last byte
            r_st <= r_in_last ? C_FLD_CLEAR : n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_ok  <= n_st.nul_seen && !n_st.failed;
            r_out_len <= n_st.nul_seen ? n_st.text_len : 8'd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_len, r_out_ok};

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.byte_pos <= C_MAX_POS)
        else $error("byte position past capacity");

    a_octet_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.octet_val <= C_OCTET_MAX)
        else $error("octet value above 255");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.digit_cnt <= C_DIG_MAX)
        else $error("too many octet digits held");

    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_out_valid && r_st.byte_pos == '0))
        else $error("last byte did not load result and clear field");

endmodule
